>>> src/stt_pkg.sv
// Shared types, codes and helper functions of the source text tokenizer.
package stt_pkg;

	localparam int POS_BITS = 16;
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	typedef enum logic [3:0] {
		M_IDLE,
		M_NUM,
		M_STR,
		M_IDENT,
		M_COMMENT,
		M_SLASH,
		M_EQ,
		M_BANG,
		M_LT,
		M_GT,
		M_ERROR,
		M_DONE
	} mode_t;

	localparam logic [5:0] K_NUMBER = 6'd0;
	localparam logic [5:0] K_STRING = 6'd1;
	localparam logic [5:0] K_IDENT  = 6'd2;
	localparam logic [5:0] K_LET    = 6'd3;
	localparam logic [5:0] K_PLUS   = 6'd13;
	localparam logic [5:0] K_MINUS  = 6'd14;
	localparam logic [5:0] K_STAR   = 6'd15;
	localparam logic [5:0] K_SLASH  = 6'd16;
	localparam logic [5:0] K_MOD    = 6'd17;
	localparam logic [5:0] K_ASSIGN = 6'd18;
	localparam logic [5:0] K_EQ     = 6'd19;
	localparam logic [5:0] K_NEQ    = 6'd20;
	localparam logic [5:0] K_LT     = 6'd21;
	localparam logic [5:0] K_GT     = 6'd22;
	localparam logic [5:0] K_LEQ    = 6'd23;
	localparam logic [5:0] K_GEQ    = 6'd24;
	localparam logic [5:0] K_LPAREN = 6'd25;
	localparam logic [5:0] K_RPAREN = 6'd26;
	localparam logic [5:0] K_LBRACE = 6'd27;
	localparam logic [5:0] K_RBRACE = 6'd28;
	localparam logic [5:0] K_SEMI   = 6'd29;
	localparam logic [5:0] K_COMMA  = 6'd30;
	localparam logic [5:0] K_END    = 6'd31;
	localparam logic [5:0] K_ERROR  = 6'd32;

	localparam logic [1:0] E_NONE    = 2'd0;
	localparam logic [1:0] E_BANG    = 2'd1;
	localparam logic [1:0] E_UNKNOWN = 2'd2;

	localparam int NUM_KW = 10;
	localparam logic [47:0] KW_TEXT [NUM_KW] = '{
		48'h00000_06C6574,
		48'h0000_0000_6966,
		48'h0000_656C_7365,
		48'h0077_6869_6C65,
		48'h0000_0000_666E,
		48'h7265_7475_726E,
		48'h0070_7269_6E74,
		48'h0069_6E70_7574,
		48'h0000_7472_7565,
		48'h0066_616C_7365
	};
	localparam logic [15:0] KW_LEN [NUM_KW] = '{
		16'd3, 16'd2, 16'd4, 16'd5, 16'd2, 16'd6, 16'd5, 16'd5, 16'd4, 16'd5
	};

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] line;
		logic [15:0] start;
		logic [15:0] length;
		logic [1:0]  err;
	} tok_t;

	typedef struct packed {
		tok_t tok;
		logic last;
	} fifo_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == "_");
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	function automatic logic [15:0] clamp16(input logic [POS_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] v);
		return (v < POS_MAX) ? v + 1'b1 : POS_MAX;
	endfunction

	function automatic logic [5:0] word_kind(input logic [15:0] cnt, input logic [47:0] kw,
			input logic ovf);
		logic [5:0] k;
		k = K_IDENT;
		if (!ovf) begin
			for (int i = NUM_KW - 1; i >= 0; i--) begin
				if (cnt == KW_LEN[i] && kw == KW_TEXT[i]) begin
					k = K_LET + 6'(i);
				end
			end
		end
		return k;
	endfunction

	function automatic logic [5:0] op_kind(input logic [7:0] c, output logic hit);
		logic [5:0] k;
		hit = 1'b1;
		case (c)
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"*": k = K_STAR;
			"%": k = K_MOD;
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			";": k = K_SEMI;
			",": k = K_COMMA;
			default: begin
				k = K_ERROR;
				hit = 1'b0;
			end
		endcase
		return k;
	endfunction

	function automatic logic [5:0] flush_kind(input mode_t m, input logic [15:0] cnt,
			input logic [47:0] kw, input logic ovf);
		logic [5:0] k;
		case (m)
			M_NUM:   k = K_NUMBER;
			M_STR:   k = K_STRING;
			M_IDENT: k = word_kind(cnt, kw, ovf);
			M_SLASH: k = K_SLASH;
			M_EQ:    k = K_ASSIGN;
			M_LT:    k = K_LT;
			M_GT:    k = K_GT;
			M_BANG:  k = K_ERROR;
			default: k = K_ERROR;
		endcase
		return k;
	endfunction

endpackage

>>> src/source_text_tokenizer_top.sv
// Top level of the source text tokenizer: streaming lexer with token queue.
// Flow: a byte is registered, lexed from that register, and its tokens are written
// into the queue and offered from there; an item is taken every cycle while each byte
// yields at most one token and the output accepts, and the single output port drains tokens one at a time.
// Reset: asynchronous, restores line 1, offset 0, idle lexer and an empty queue.
module source_text_tokenizer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // text_byte
	input  logic        s_tlast,   // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // token_kind, token_line, token_start, token_length, error_code
	output logic        m_tlast    // last_of_run
);
	import stt_pkg::*;

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        fin_s1;
	logic        adv;
	logic        pop;
	logic        room;

	mode_t                mode_q, mode_v;
	logic [15:0]          line_q, line_v;
	logic [POS_BITS-1:0]  pos_q, pos_v;
	logic [POS_BITS-1:0]  tbeg_q, tbeg_v;
	logic [15:0]          tcnt_q, tcnt_v;
	logic [47:0]          kw_q, kw_v;
	logic                 ovf_q, ovf_v;

	tok_t       slot [4];
	logic [3:0] slot_v;
	tok_t       res [3];
	logic [1:0] n_res;
	logic       used;
	logic       do_rst;
	logic       op_hit;
	logic [5:0] op_k;

	fifo_t      mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign pop      = m_tvalid && m_tready;
	assign room     = (cnt_q <= 3'd1) || (cnt_q == 3'd2 && pop);
	assign adv      = v_s1 && room;
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			fin_s1  <= s_tlast;
		end
	end

	always_comb begin
		mode_v = mode_q;
		line_v = line_q;
		pos_v  = pos_q;
		tbeg_v = tbeg_q;
		tcnt_v = tcnt_q;
		kw_v   = kw_q;
		ovf_v  = ovf_q;
		slot_v = '0;
		for (int i = 0; i < 4; i++) begin
			slot[i] = '0;
		end
		used   = 1'b0;
		do_rst = 1'b0;
		op_k   = op_kind(byte_s1, op_hit);

		if (mode_q == M_DONE) begin
			do_rst = fin_s1;
		end else if (mode_q == M_ERROR) begin
			if (byte_s1 == "\n" && line_q != 16'hFFFF) begin
				line_v = line_q + 16'd1;
			end
			pos_v = pos_inc(pos_q);
			if (fin_s1) begin
				slot_v[3] = 1'b1;
				slot[3]   = '{K_END, line_v, clamp16(pos_v), 16'd0, E_NONE};
				do_rst    = 1'b1;
			end
		end else if (byte_s1 == 8'd0) begin
			if (mode_q inside {M_NUM, M_STR, M_IDENT, M_SLASH, M_EQ, M_LT, M_GT, M_BANG}) begin
				slot_v[2] = 1'b1;
				slot[2]   = '{flush_kind(mode_q, tcnt_q, kw_q, ovf_q), line_q, clamp16(tbeg_q),
					(mode_q inside {M_NUM, M_STR, M_IDENT}) ? tcnt_q : 16'd1,
					(mode_q == M_BANG) ? E_BANG : E_NONE};
			end
			slot_v[3] = 1'b1;
			slot[3]   = '{K_END, line_q, clamp16(pos_q), 16'd0, E_NONE};
			if (fin_s1) begin
				do_rst = 1'b1;
			end else begin
				mode_v = M_DONE;
			end
		end else begin
			case (mode_q)
				M_NUM, M_IDENT: begin
					if ((mode_q == M_NUM) ? (is_digit(byte_s1) || byte_s1 == ".")
							: is_word(byte_s1)) begin
						used = 1'b1;
					end else begin
						slot_v[0] = 1'b1;
						slot[0]   = '{(mode_q == M_NUM) ? K_NUMBER : word_kind(tcnt_q, kw_q, ovf_q),
							line_q, clamp16(tbeg_q), tcnt_q, E_NONE};
						mode_v    = M_IDLE;
					end
				end
				M_STR: begin
					used = 1'b1;
					if (byte_s1 == "\"") begin
						slot_v[0] = 1'b1;
						slot[0]   = '{K_STRING, line_q, clamp16(tbeg_q), tcnt_q, E_NONE};
						mode_v    = M_IDLE;
					end
				end
				M_COMMENT: begin
					if (byte_s1 == "\n") begin
						mode_v = M_IDLE;
					end else begin
						used = 1'b1;
					end
				end
				M_SLASH: begin
					if (byte_s1 == "/") begin
						used   = 1'b1;
						mode_v = M_COMMENT;
					end else begin
						slot_v[0] = 1'b1;
						slot[0]   = '{K_SLASH, line_q, clamp16(tbeg_q), 16'd1, E_NONE};
						mode_v    = M_IDLE;
					end
				end
				M_EQ, M_LT, M_GT, M_BANG: begin
					slot_v[0] = 1'b1;
					mode_v    = M_IDLE;
					if (byte_s1 == "=") begin
						used    = 1'b1;
						slot[0] = '{(mode_q == M_EQ) ? K_EQ : (mode_q == M_LT) ? K_LEQ :
							(mode_q == M_GT) ? K_GEQ : K_NEQ,
							line_q, clamp16(tbeg_q), 16'd2, E_NONE};
					end else if (mode_q == M_BANG) begin
						used    = 1'b1;
						slot[0] = '{K_ERROR, line_q, clamp16(tbeg_q), 16'd1, E_BANG};
						mode_v  = M_ERROR;
					end else begin
						slot[0] = '{(mode_q == M_EQ) ? K_ASSIGN : (mode_q == M_LT) ? K_LT : K_GT,
							line_q, clamp16(tbeg_q), 16'd1, E_NONE};
					end
				end
				default: begin
				end
			endcase

			if (used && (mode_q == M_NUM || mode_q == M_IDENT ||
					(mode_q == M_STR && byte_s1 != "\""))) begin
				tcnt_v = (tcnt_q != 16'hFFFF) ? tcnt_q + 16'd1 : tcnt_q;
				ovf_v  = ovf_q || (tcnt_v > 16'd6);
				kw_v   = {kw_q[39:0], byte_s1};
			end

			if (!used && !is_space(byte_s1)) begin
				if (is_digit(byte_s1) || is_alpha(byte_s1) || byte_s1 == "_") begin
					tbeg_v = pos_q;
					tcnt_v = 16'd1;
					kw_v   = {40'd0, byte_s1};
					ovf_v  = 1'b0;
					mode_v = is_digit(byte_s1) ? M_NUM : M_IDENT;
				end else if (byte_s1 == "\"") begin
					tbeg_v = pos_inc(pos_q);
					tcnt_v = 16'd0;
					kw_v   = '0;
					ovf_v  = 1'b0;
					mode_v = M_STR;
				end else if (byte_s1 inside {"/", "=", "!", "<", ">"}) begin
					tbeg_v = pos_q;
					tcnt_v = 16'd1;
					kw_v   = '0;
					ovf_v  = 1'b0;
					case (byte_s1)
						"/":     mode_v = M_SLASH;
						"=":     mode_v = M_EQ;
						"!":     mode_v = M_BANG;
						"<":     mode_v = M_LT;
						default: mode_v = M_GT;
					endcase
				end else begin
					slot_v[1] = 1'b1;
					slot[1]   = '{op_k, line_q, clamp16(pos_q), 16'd1,
						op_hit ? E_NONE : E_UNKNOWN};
					if (!op_hit) begin
						mode_v = M_ERROR;
					end
				end
			end

			if (byte_s1 == "\n" && line_q != 16'hFFFF) begin
				line_v = line_q + 16'd1;
			end
			pos_v = pos_inc(pos_q);

			if (fin_s1) begin
				if (mode_v inside {M_NUM, M_STR, M_IDENT, M_SLASH, M_EQ, M_LT, M_GT, M_BANG}) begin
					slot_v[2] = 1'b1;
					slot[2]   = '{flush_kind(mode_v, tcnt_v, kw_v, ovf_v), line_v, clamp16(tbeg_v),
						(mode_v inside {M_NUM, M_STR, M_IDENT}) ? tcnt_v : 16'd1,
						(mode_v == M_BANG) ? E_BANG : E_NONE};
				end
				slot_v[3] = 1'b1;
				slot[3]   = '{K_END, line_v, clamp16(pos_v), 16'd0, E_NONE};
				do_rst    = 1'b1;
			end
		end

		if (do_rst) begin
			mode_v = M_IDLE;
			line_v = 16'd1;
			pos_v  = '0;
			tbeg_v = '0;
			tcnt_v = '0;
			kw_v   = '0;
			ovf_v  = 1'b0;
		end
	end

	always_comb begin
		n_res = 2'd0;
		for (int i = 0; i < 3; i++) begin
			res[i] = '0;
		end
		for (int i = 0; i < 4; i++) begin
			if (slot_v[i] && n_res != 2'd3) begin
				res[n_res] = slot[i];
				n_res      = n_res + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			line_q <= 16'd1;
			pos_q  <= '0;
			tbeg_q <= '0;
			tcnt_q <= '0;
			kw_q   <= '0;
			ovf_q  <= 1'b0;
		end else if (adv) begin
			mode_q <= mode_v;
			line_q <= line_v;
			pos_q  <= pos_v;
			tbeg_q <= tbeg_v;
			tcnt_q <= tcnt_v;
			kw_q   <= kw_v;
			ovf_q  <= ovf_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < n_res) begin
					mem_q[wp_q + 2'(i)] <= '{res[i], (2'(i) == n_res - 2'd1)};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (adv) begin
				wp_q <= wp_q + n_res;
			end
			if (pop) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q - {2'd0, pop} + (adv ? {1'b0, n_res} : 3'd0);
		end
	end

	assign m_tvalid = cnt_q != 3'd0;
	assign m_tdata  = {mem_q[rp_q].tok.err, mem_q[rp_q].tok.length, mem_q[rp_q].tok.start,
		mem_q[rp_q].tok.line, mem_q[rp_q].tok.kind};
	assign m_tlast  = mem_q[rp_q].last;

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("token queue overflow");

	a_fifo_room: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> ({1'b0, cnt_q} + {2'd0, n_res} <= 4'd4 + {3'd0, pop}))
		else $error("token queue written without room");

	a_end_token: assert property (@(posedge clk) disable iff (!arst_n)
		adv && fin_s1 && mode_q != M_DONE |-> n_res != 2'd0)
		else $error("final byte gave no end token");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && fin_s1 |=> mode_q == M_IDLE && line_q == 16'd1 && pos_q == '0)
		else $error("lexer not restarted after final byte");

endmodule
